// ----- hw/rtl/mmep_pkg.sv -----
// Shared constants, command/status types and level test for the min/max envelope pyramid.
package mmep_pkg;

  localparam int MAX_LEVELS   = 16;
  localparam int SAMPLE_WIDTH = 16;
  localparam int LVL_W        = 4;
  localparam int CNT_W        = 17;
  localparam int POS_W        = 15;

  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(MAX_LEVELS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic take;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic emit_now;
    logic last;
    logic out_free;
  } status_t;

  // True when a level gives an envelope for the sample that brings the count to nxt:
  // its block is complete, or the vector ends and 2**lvl is below the count.
  function automatic logic emits(logic [CNT_W-1:0] nxt, logic fin, logic [LVL_W-1:0] lvl);
    logic [CNT_W-1:0] pow;
    logic [CNT_W-1:0] mask;
    pow  = CNT_W'(1) << lvl;
    mask = (pow << 1) - CNT_W'(1);
    return ((nxt & mask) == '0) || (fin && (pow < nxt));
  endfunction

endpackage

// ----- hw/rtl/mmep_ctrl.sv -----
// Controller state machine: accepts a sample, then walks the emitting levels.
module mmep_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mmep_pkg::status_t st,
  output mmep_pkg::cmd_t    cmd
);

  mmep_pkg::state_t state;
  mmep_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmep_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mmep_pkg::ST_IDLE: begin
        if (in_valid) state_next = mmep_pkg::ST_WALK;
      end
      mmep_pkg::ST_WALK: begin
        if (!st.emit_now) begin
          state_next = mmep_pkg::ST_IDLE;
        end else if (st.out_free && st.last) begin
          state_next = mmep_pkg::ST_IDLE;
        end
      end
      default: state_next = mmep_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    case (state)
      mmep_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      mmep_pkg::ST_WALK: begin
        cmd.emit = st.emit_now && st.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ----- hw/rtl/mmep_datapath.sv -----
// Datapath: sample count, per-level running envelopes and the output register.
module mmep_datapath (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic signed [mmep_pkg::SAMPLE_WIDTH-1:0]    sample,
  input  logic                                        final_sample,
  input  mmep_pkg::cmd_t                              cmd,
  output mmep_pkg::status_t                           st,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [mmep_pkg::LVL_W-1:0]                  level,
  output logic [mmep_pkg::POS_W-1:0]                  position,
  output logic signed [mmep_pkg::SAMPLE_WIDTH-1:0]    env_min,
  output logic signed [mmep_pkg::SAMPLE_WIDTH-1:0]    env_max,
  output logic                                        last_of_run
);

  logic [mmep_pkg::CNT_W-1:0]               cnt;
  logic [mmep_pkg::CNT_W-1:0]               cnt_inc;
  logic [mmep_pkg::CNT_W-1:0]               nxt;
  logic                                     fin;
  logic [mmep_pkg::CNT_W-2:0]               pos_sh;
  logic [mmep_pkg::LVL_W-1:0]               lvl;
  logic signed [mmep_pkg::SAMPLE_WIDTH-1:0] pmin [mmep_pkg::MAX_LEVELS];
  logic signed [mmep_pkg::SAMPLE_WIDTH-1:0] pmax [mmep_pkg::MAX_LEVELS];

  assign cnt_inc = cnt + mmep_pkg::CNT_W'(1);

  assign st.emit_now = mmep_pkg::emits(nxt, fin, lvl);
  assign st.last     = (lvl == mmep_pkg::LVL_LAST) ||
                       !mmep_pkg::emits(nxt, fin, lvl + mmep_pkg::LVL_W'(1));
  assign st.out_free = !out_valid || !out_stall;

  // Every level updates its open block at once; a level whose block starts here reloads.
  for (genvar k = 0; k < mmep_pkg::MAX_LEVELS; k++) begin : g_lvl
    localparam logic [mmep_pkg::CNT_W-1:0] SPAN_MASK =
      (mmep_pkg::CNT_W'(2) << k) - mmep_pkg::CNT_W'(1);
    always_ff @(posedge clk) begin
      if (cmd.take) begin
        if ((cnt & SPAN_MASK) == '0) begin
          pmin[k] <= sample;
          pmax[k] <= sample;
        end else begin
          if (sample < pmin[k]) pmin[k] <= sample;
          if (sample > pmax[k]) pmax[k] <= sample;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      nxt <= '0;
      fin <= 1'b0;
      lvl <= '0;
    end else if (cmd.take) begin
      cnt <= final_sample ? '0 : cnt_inc;
      nxt <= cnt_inc;
      fin <= final_sample;
      lvl <= '0;
    end else if (cmd.emit) begin
      lvl <= lvl + mmep_pkg::LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pos_sh <= cnt[mmep_pkg::CNT_W-1:1];
    end else if (cmd.emit) begin
      pos_sh <= pos_sh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      level       <= lvl;
      position    <= pos_sh[mmep_pkg::POS_W-1:0];
      env_min     <= pmin[lvl];
      env_max     <= pmax[lvl];
      last_of_run <= st.last;
    end
  end

endmodule

// ----- hw/rtl/min_max_envelope_pyramid.sv -----
// Top level of the min/max envelope pyramid: controller plus datapath.
//
// The input channel carries one signed sample per transfer, with final_sample
// set on the last sample of a vector. The output channel carries envelopes:
// level, position within the level, minimum and maximum over the block, and
// last_of_run on the final envelope caused by one input sample.
// All levels fold the new sample into their open block in the cycle of the
// input transfer. The controller then walks the levels upward from level 0,
// one envelope per cycle while the receiver does not stall, and stops at the
// first level that has nothing to give; because the emitting levels always
// form a run starting at level 0, no emitting level is missed. Every input,
// also one that causes no envelope, passes through the walk state.
// The first envelope is written to the output register from the walk state
// that follows the input transfer, once that register is free. On average a
// sample causes about one envelope.
// While the receiver stalls, the output register holds its envelope and the
// walk waits; in_stall stays high until the walk for the current sample ends.
// Reset clears the sample count and the output valid flag; the running
// envelopes need no reset since the first sample of a vector loads them all.
module min_max_envelope_pyramid (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [mmep_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic                                     final_sample,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [mmep_pkg::LVL_W-1:0]               level,
  output logic [mmep_pkg::POS_W-1:0]               position,
  output logic signed [mmep_pkg::SAMPLE_WIDTH-1:0] env_min,
  output logic signed [mmep_pkg::SAMPLE_WIDTH-1:0] env_max,
  output logic                                     last_of_run
);

  // Commands flow from the controller, status flows back from the datapath.
  mmep_pkg::cmd_t    cmd;
  mmep_pkg::status_t st;

  mmep_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  mmep_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .final_sample (final_sample),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level        (level),
    .position     (position),
    .env_min      (env_min),
    .env_max      (env_max),
    .last_of_run  (last_of_run)
  );

endmodule

// ----- hw/rtl/mmep_checker.sv -----
// Port-level checker for the min/max envelope pyramid, bound to the top level.
module mmep_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     in_valid,
  input logic                                     in_stall,
  input logic                                     out_valid,
  input logic                                     out_stall,
  input logic [mmep_pkg::LVL_W-1:0]               level,
  input logic [mmep_pkg::POS_W-1:0]               position,
  input logic signed [mmep_pkg::SAMPLE_WIDTH-1:0] env_min,
  input logic signed [mmep_pkg::SAMPLE_WIDTH-1:0] env_max,
  input logic                                     last_of_run
);

  // A held envelope stays put until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(level) && $stable(position) &&
      $stable(env_min) && $stable(env_max) && $stable(last_of_run))
    else $error("output envelope changed while stalled");

  // The block is ready for a sample right after reset.
  a_ready_after_rst: assert property (@(posedge clk)
    !rst && $past(rst) |-> !in_stall)
    else $error("input stalled after reset");

  // Every sample is followed by a walk of its levels, during which the input is stalled.
  a_take_then_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken in back-to-back cycles");

  // While an envelope that is not the last of its run waits in the output
  // register, more envelopes of the same sample follow, so no new sample is taken.
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> in_stall)
    else $error("input taken in the middle of a run");

  // The minimum of a block never exceeds its maximum.
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> env_min <= env_max)
    else $error("envelope minimum above maximum");

endmodule

bind min_max_envelope_pyramid mmep_checker u_mmep_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .level       (level),
  .position    (position),
  .env_min     (env_min),
  .env_max     (env_max),
  .last_of_run (last_of_run)
);

// ----- bench/mmep_checker.sv -----
`timescale 1ns / 100ps
// Envelope checker: predicts the pyramid output of each accepted sample and compares it.

module mmep_scoreboard (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  input  logic                                     in_stall,
  input  logic signed [mmep_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic                                     final_sample,
  input  logic                                     out_valid,
  input  logic                                     out_stall,
  input  logic [mmep_pkg::LVL_W-1:0]               level,
  input  logic [mmep_pkg::POS_W-1:0]               position,
  input  logic signed [mmep_pkg::SAMPLE_WIDTH-1:0] env_min,
  input  logic signed [mmep_pkg::SAMPLE_WIDTH-1:0] env_max,
  input  logic                                     last_of_run,
  output int                                       errors,
  output int                                       outstanding
);

  localparam int SW       = mmep_pkg::SAMPLE_WIDTH;
  localparam int CW       = mmep_pkg::CNT_W;
  localparam int REPORTED = 10;

  typedef struct packed {
    logic [mmep_pkg::LVL_W-1:0] lvl;
    logic [mmep_pkg::POS_W-1:0] pos;
    logic signed [SW-1:0]       env_lo;
    logic signed [SW-1:0]       env_hi;
    logic                       tail;
  } envelope_t;

  logic [CW-1:0]        vec_count = '0;
  logic signed [SW-1:0] open_min [mmep_pkg::MAX_LEVELS];
  logic signed [SW-1:0] open_max [mmep_pkg::MAX_LEVELS];
  envelope_t            expected_env[$];
  int                   mismatch_count = 0;

  // Folds one sample into every level and queues the envelopes that close or flush.
  task automatic fold_sample(input logic signed [SW-1:0] s, input logic fin);
    logic [CW-1:0] idx;
    logic [CW-1:0] nxt;
    logic [CW-1:0] span;
    envelope_t     burst[$];
    envelope_t     e;
    idx = vec_count;
    nxt = idx + 1'b1;
    for (int k = 0; k < mmep_pkg::MAX_LEVELS && k < 16; k++) begin
      span = (CW'(1) << (k + 1)) - CW'(1);
      if ((idx & span) == '0) begin
        open_min[k] = s;
        open_max[k] = s;
      end else begin
        if (s < open_min[k]) open_min[k] = s;
        if (s > open_max[k]) open_max[k] = s;
      end
      if (((nxt & span) == '0) || (fin && ((CW'(1) << k) < nxt))) begin
        e.lvl    = mmep_pkg::LVL_W'(k);
        e.pos    = mmep_pkg::POS_W'(idx >> (k + 1));
        e.env_lo = open_min[k];
        e.env_hi = open_max[k];
        e.tail   = 1'b0;
        burst    = {burst, e};
      end
    end
    if (burst.size() > 0) burst[burst.size() - 1].tail = 1'b1;
    foreach (burst[i]) expected_env = {expected_env, burst[i]};
    vec_count = fin ? '0 : nxt;
  endtask

  always @(posedge clk) begin : watch
    envelope_t want;
    envelope_t got;
    if (rst) begin
      vec_count = '0;
      expected_env.delete();
    end else begin
      // Results are checked before the sample of this edge is folded in.
      if (out_valid && !out_stall) begin
        got = '{level, position, env_min, env_max, last_of_run};
        if (expected_env.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORTED)
            $display("%0t: unexpected envelope level %0d pos %0d min %0d max %0d last %0b",
                     $realtime, got.lvl, got.pos, got.env_lo, got.env_hi, got.tail);
        end else begin
          want = expected_env.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORTED) begin
              $display("%0t: envelope mismatch", $realtime);
              $display("  expected level %0d pos %0d min %0d max %0d last %0b",
                       want.lvl, want.pos, want.env_lo, want.env_hi, want.tail);
              $display("  actual   level %0d pos %0d min %0d max %0d last %0b",
                       got.lvl, got.pos, got.env_lo, got.env_hi, got.tail);
            end
          end
        end
      end
      if (in_valid && !in_stall) fold_sample(sample, final_sample);
    end
    errors      <= mismatch_count;
    outstanding <= expected_env.size();
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Bench top for the min/max envelope pyramid: clock, reset, sample stimulus, stalls and verdict.

module testbench;

  localparam int SW             = mmep_pkg::SAMPLE_WIDTH;
  localparam int RANDOM_SAMPLES = 91;
  localparam int DRAIN_CYCLES   = 40;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          in_valid     = 1'b0;
  logic                          in_stall;
  logic signed [SW-1:0]          sample       = '0;
  logic                          final_sample = 1'b0;
  logic                          out_valid;
  logic                          out_stall    = 1'b0;
  logic [mmep_pkg::LVL_W-1:0]    level;
  logic [mmep_pkg::POS_W-1:0]    position;
  logic signed [SW-1:0]          env_min;
  logic signed [SW-1:0]          env_max;
  logic                          last_of_run;

  int   errors;
  int   outstanding;
  // While quiet is high neither side idles, so the block runs at its full rate.
  logic quiet      = 1'b0;
  int   stall_left = 0;
  int   sent       = 0;

  min_max_envelope_pyramid dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .final_sample (final_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level        (level),
    .position     (position),
    .env_min      (env_min),
    .env_max      (env_max),
    .last_of_run  (last_of_run)
  );

  mmep_scoreboard u_scoreboard (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .final_sample (final_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level        (level),
    .position     (position),
    .env_min      (env_min),
    .env_max      (env_max),
    .last_of_run  (last_of_run),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver side: random runs of stall and free cycles. Most stalls are short,
  // a few are long enough to back the walk up over several levels, and now and
  // then a long free stretch lets the block run unhindered.
  always @(posedge clk) begin : stall_gen
    int pick;
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 6);
      end else if (pick < 90) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else if (pick < 97) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(8, 30);
      end else begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(20, 60);
      end
    end
  end

  // Idle cycles on the input side after a transfer: usually none or a few,
  // sometimes a long pause so that gaps land at every step of the level walk.
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Sample values lean toward the extremes and toward small values so that
  // ties and sign changes inside one block are common.
  function automatic logic signed [SW-1:0] pick_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return {1'b1, {(SW-1){1'b0}}};
    if (pick < 20) return {1'b0, {(SW-1){1'b1}}};
    if (pick < 35) return SW'($signed($urandom_range(0, 8)) - 4);
    return SW'($urandom);
  endfunction

  // Presents one sample and holds it until the block takes it. A gap of zero
  // leaves in_valid high so that the next call continues back to back.
  task automatic send_sample(input logic signed [SW-1:0] s, input logic fin);
    int gap;
    in_valid     <= 1'b1;
    sample       <= s;
    final_sample <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sends one vector of random samples with the final flag on its last one.
  task automatic send_vector(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  initial begin : stimulus
    int pick;
    int len;
    int goal;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A vector of one sample is too short to give any envelope.
    send_sample(16'sh7fff, 1'b1);
    // Two samples at opposite extremes close exactly one level-0 block.
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    // Three samples: the final one flushes an open level-0 block and level 1.
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sh0001, 1'b0);
    send_sample(16'sh0001, 1'b1);
    // Eight samples close levels 0 to 2 together on the last transfer.
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(-16'sh5556, 1'b0);
    send_sample(16'sh8001, 1'b0);
    send_sample(16'sh7ffe, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0000, 1'b1);
    // Five equal samples: minimum and maximum agree on every level.
    repeat (4) send_sample(16'sh1234, 1'b0);
    send_sample(16'sh1234, 1'b1);

    // Random vectors, mostly short with some longer ones; about one in five
    // runs with neither side idling. The last vector is cut to the sample goal.
    goal = sent + RANDOM_SAMPLES;
    while (sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) len = $urandom_range(1, 8);
      else if (pick < 90) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 90);
      if (len > goal - sent) len = goal - sent;
      quiet <= ($urandom_range(0, 4) == 0);
      send_vector(len);
    end

    // Drain: let the receiver run free, wait for every envelope, then watch
    // for anything extra that the block might still produce.
    in_valid <= 1'b0;
    quiet    <= 1'b1;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- min_max_envelope_pyramid.f -----
hw/rtl/mmep_pkg.sv
hw/rtl/mmep_ctrl.sv
hw/rtl/mmep_datapath.sv
hw/rtl/min_max_envelope_pyramid.sv
hw/rtl/mmep_checker.sv
bench/mmep_checker.sv
bench/testbench.sv
